/* hdl/nca_pkg.sv */
// Shared constants, types and helpers for the nearest-center assignment block.
// No dependencies; every other file in hdl/ except nca_ram refers to this package by scope.
`timescale 1ns / 1ps

package nca_pkg;

  localparam int NUM_CENTERS = 16;
  localparam int NUM_DIMS    = 16;

  localparam int CIDX_W  = 4;   // center_index field
  localparam int DIDX_W  = 4;   // element_index field
  localparam int CFG_W   = 5;   // configuration register width
  localparam int CNT_W   = 5;   // effective counts 1..16
  localparam int VAL_W   = 16;
  localparam int SQ_W    = 32;  // square of a 17-bit difference fits in 32 bits
  localparam int ACC_W   = 36;

  localparam int TBL_DEPTH = NUM_CENTERS * NUM_DIMS;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] CFG_RESET = CNT_W'(16);

  typedef enum logic {
    CFG_CENTERS = 1'b0,
    CFG_DIMS    = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_POINT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    logic                     is_point;
    logic                     first;
    logic                     last;
    logic [CIDX_W-1:0]        center;
    logic [DIDX_W-1:0]        elem;
    logic signed [VAL_W-1:0]  value;
    logic [CNT_W-1:0]         ncent;
  } job_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                   input logic [CNT_W-1:0] hi);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (CNT_W'(v) > hi) begin
      r = hi;
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

/* hdl/nca_if.sv */
// Valid/ready channel interfaces: point and center elements in, assignments out.
// Depends on nca_pkg for field widths.
`timescale 1ns / 1ps

interface nca_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [nca_pkg::CIDX_W-1:0]           center_index;
  logic [nca_pkg::DIDX_W-1:0]           element_index;
  logic signed [nca_pkg::VAL_W-1:0]     value;

  modport source (output valid, cmd, center_index, element_index, value, input ready);
  modport sink   (input valid, cmd, center_index, element_index, value, output ready);
endinterface

interface nca_out_if;
  logic                           valid;
  logic                           ready;
  logic [nca_pkg::CIDX_W-1:0]     cluster_index;
  logic [nca_pkg::ACC_W-1:0]      min_distance;

  modport source (output valid, cluster_index, min_distance, input ready);
  modport sink   (input valid, cluster_index, min_distance, output ready);
endinterface

/* hdl/nca_front.sv */
// Front end: holds the configuration registers, accepts input items, drops
// items that do nothing and tags the rest as jobs. Depends on nca_pkg, nca_if.
`timescale 1ns / 1ps

module nca_front (
  input  logic                        clk,
  input  logic                        rst,
  nca_in_if.sink                      elem,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [nca_pkg::CFG_W-1:0]   cfg_data,
  output nca_pkg::job_t               job,
  output logic                        job_push,
  input  logic                        q_full
);

  logic [nca_pkg::CFG_W-1:0] centers_cfg;
  logic [nca_pkg::CFG_W-1:0] dims_cfg;
  logic [nca_pkg::CNT_W-1:0] nc;
  logic [nca_pkg::CNT_W-1:0] nd;
  logic                      accept;
  logic                      is_point;
  logic                      keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_cfg <= nca_pkg::CFG_W'(nca_pkg::CFG_RESET);
      dims_cfg    <= nca_pkg::CFG_W'(nca_pkg::CFG_RESET);
    end else if (cfg_we) begin
      unique case (nca_pkg::cfg_reg_t'(cfg_index))
        nca_pkg::CFG_CENTERS: centers_cfg <= cfg_data;
        nca_pkg::CFG_DIMS:    dims_cfg    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nc = nca_pkg::clamp_count(centers_cfg, nca_pkg::CNT_W'(nca_pkg::NUM_CENTERS));
  assign nd = nca_pkg::clamp_count(dims_cfg, nca_pkg::CNT_W'(nca_pkg::NUM_DIMS));

  assign elem.ready = !q_full;
  assign accept     = elem.valid && elem.ready;
  assign is_point   = (nca_pkg::cmd_t'(elem.cmd) == nca_pkg::CMD_POINT);

  always_comb begin
    if (is_point) begin
      keep = ({1'b0, elem.element_index} < nd);
    end else begin
      keep = ({1'b0, elem.center_index} < nca_pkg::CNT_W'(nca_pkg::NUM_CENTERS)) &&
             ({1'b0, elem.element_index} < nca_pkg::CNT_W'(nca_pkg::NUM_DIMS));
    end
  end

  assign job_push = accept && keep;

  always_comb begin
    job.is_point = is_point;
    job.first    = (elem.element_index == '0);
    job.last     = ({1'b0, elem.element_index} == (nd - nca_pkg::CNT_W'(1)));
    job.center   = elem.center_index;
    job.elem     = elem.element_index;
    job.value    = elem.value;
    job.ncent    = nc;
  end

endmodule

/* hdl/nca_queue.sv */
// Short job queue between front end and back end.
// Depends on nca_pkg for the job type and depth.
`timescale 1ns / 1ps

module nca_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  nca_pkg::job_t   din,
  output logic            full,
  input  logic            pop,
  output nca_pkg::job_t   dout,
  output logic            empty
);

  nca_pkg::job_t                slots [nca_pkg::QUEUE_DEPTH];
  logic [nca_pkg::QPTR_W-1:0]   wr_ptr;
  logic [nca_pkg::QPTR_W-1:0]   rd_ptr;
  logic [nca_pkg::QCNT_W-1:0]   count;
  logic                         do_push;
  logic                         do_pop;

  assign full    = (count == nca_pkg::QCNT_W'(nca_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + nca_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + nca_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + nca_pkg::QCNT_W'(1);
        2'b01:   count <= count - nca_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/nca_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module nca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/nca_back.sv */
// Back end: writes center elements into the table and, for point elements,
// sweeps the centers one per cycle through read, square and accumulate stages.
// Depends on nca_pkg, nca_if and nca_ram.
`timescale 1ns / 1ps

module nca_back (
  input  logic            clk,
  input  logic            rst,
  input  nca_pkg::job_t   qjob,
  input  logic            q_empty,
  output logic            q_pop,
  nca_out_if.source       result
);

  nca_pkg::back_state_t state;
  nca_pkg::back_state_t state_next;
  nca_pkg::job_t        cur;

  logic [nca_pkg::CIDX_W-1:0]  c0;
  logic                        lc0;
  logic                        start;
  logic                        do_load;
  logic                        issue;

  logic                        v1;
  logic [nca_pkg::CIDX_W-1:0]  c1;
  logic                        lc1;
  logic [nca_pkg::VAL_W-1:0]   rdata;
  logic signed [nca_pkg::VAL_W:0]     diff;
  logic signed [2*nca_pkg::VAL_W+1:0] prod;

  logic                        v2;
  logic [nca_pkg::CIDX_W-1:0]  c2;
  logic                        lc2;
  logic [nca_pkg::SQ_W-1:0]    sq2;

  logic [nca_pkg::ACC_W-1:0]   acc [nca_pkg::NUM_CENTERS];
  logic [nca_pkg::ACC_W-1:0]   base;
  logic [nca_pkg::ACC_W:0]     sum;
  logic [nca_pkg::ACC_W-1:0]   acc_new;
  logic                        better;
  logic [nca_pkg::ACC_W-1:0]   best_d;
  logic [nca_pkg::CIDX_W-1:0]  best_c;
  logic                        res_load;

  logic                        out_valid;
  logic [nca_pkg::CIDX_W-1:0]  out_c;
  logic [nca_pkg::ACC_W-1:0]   out_d;

  assign lc0 = ({1'b0, c0} == (cur.ncent - nca_pkg::CNT_W'(1)));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nca_pkg::BK_IDLE: begin
        if (start) begin
          state_next = nca_pkg::BK_RUN;
        end
      end
      nca_pkg::BK_RUN: begin
        if (lc0) begin
          state_next = nca_pkg::BK_DRAIN;
        end
      end
      nca_pkg::BK_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = nca_pkg::BK_IDLE;
        end
      end
      default: state_next = nca_pkg::BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    start   = 1'b0;
    do_load = 1'b0;
    issue   = 1'b0;
    unique case (state)
      nca_pkg::BK_IDLE: begin
        start   = !q_empty && qjob.is_point && (!qjob.last || !out_valid);
        do_load = !q_empty && !qjob.is_point;
      end
      nca_pkg::BK_RUN: begin
        issue = 1'b1;
      end
      default: ;
    endcase
  end

  assign q_pop = start || do_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nca_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= qjob;
      c0  <= '0;
    end else if (issue && !lc0) begin
      c0 <= c0 + nca_pkg::CIDX_W'(1);
    end
  end

  nca_ram #(
    .WIDTH (nca_pkg::VAL_W),
    .DEPTH (nca_pkg::TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (do_load),
    .waddr ({qjob.center, qjob.elem}),
    .wdata (qjob.value),
    .raddr ({c0, cur.elem}),
    .rdata (rdata)
  );

  // stage 1: table data back, square the difference
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    c1 <= c0;
    lc1 <= lc0;
  end

  assign diff = $signed({cur.value[nca_pkg::VAL_W-1], cur.value}) -
                $signed({rdata[nca_pkg::VAL_W-1], rdata});
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    c2  <= c1;
    lc2 <= lc1;
    sq2 <= prod[nca_pkg::SQ_W-1:0];
  end

  // stage 2: saturating accumulate and running minimum
  assign base    = cur.first ? '0 : acc[c2];
  assign sum     = {1'b0, base} + (nca_pkg::ACC_W + 1)'(sq2);
  assign acc_new = sum[nca_pkg::ACC_W] ? '1 : sum[nca_pkg::ACC_W-1:0];
  assign better  = (c2 == '0) || (acc_new < best_d);
  assign res_load = v2 && lc2 && cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nca_pkg::NUM_CENTERS; i++) begin
        acc[i] <= '0;
      end
    end else if (v2) begin
      acc[c2] <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && better) begin
      best_d <= acc_new;
      best_c <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_c <= better ? c2 : best_c;
      out_d <= better ? acc_new : best_d;
    end
  end

  assign result.valid         = out_valid;
  assign result.cluster_index = out_c;
  assign result.min_distance  = out_d;

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid)
    else $error("result produced while output register occupied");

  a_center_in_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> ({1'b0, c2} < cur.ncent))
    else $error("accumulate stage on a center not in use");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == nca_pkg::BK_IDLE) |-> (!v1 && !v2))
    else $error("sequencer idle with work in the pipeline");

  a_last_center_tail: assert property (@(posedge clk) disable iff (rst)
    (v2 && lc2) |-> !v1)
    else $error("center issued after the last center of an item");

endmodule

/* hdl/nearest_center_assign.sv */
// Top level of the nearest-center assignment block: front end, job queue, back end.
// Depends on nca_pkg, nca_if, nca_front, nca_queue, nca_back.
`timescale 1ns / 1ps
//
// Usage:
//   elem   : input items. cmd 0 writes one element of one center into the table;
//            cmd 1 brings one element of a point. Element 0 restarts the sums.
//   result : one item per point, after the element with index dims_in_use - 1:
//            nearest center (lowest index on ties) and its squared distance.
//   cfg_we/cfg_index/cfg_data : register 0 centers_in_use, 1 dims_in_use;
//            write only while the block is idle.
// Timing:
//   A center load is written into the table as it leaves the queue. A point element
//   sweeps the centers in use: the back end reads the center table once per
//   center, so one table read port paced at one center per cycle sets the rate.
//   The result passes the table read, square and accumulate registers.
//   A 4-entry job queue lets the front accept items while the back end works.
// Reset: configuration returns to 16/16, sums clear, queue and output empty.
//   The center table is not cleared and must be loaded before use.
// Stall: a waiting result holds in its output register; the back end then
//   holds a final point element in the queue, and elem.ready drops once the
//   queue is full.

module nearest_center_assign (
  input  logic                        clk,
  input  logic                        rst,
  nca_in_if.sink                      elem,
  nca_out_if.source                   result,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [nca_pkg::CFG_W-1:0]   cfg_data
);

  nca_pkg::job_t  push_job;
  nca_pkg::job_t  head_job;
  logic           job_push;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  nca_front u_front (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .job       (push_job),
    .job_push  (job_push),
    .q_full    (q_full)
  );

  nca_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (push_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (head_job),
    .empty (q_empty)
  );

  nca_back u_back (
    .clk     (clk),
    .rst     (rst),
    .qjob    (head_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

/* tb/sv/nca_checker.sv */
// Scoreboard for nearest_center_assign: mirrors the center table, the running
// distance sums and both registers, predicts each assignment and compares it.
// Depends on nca_pkg and the channel interfaces in nca_if.
`timescale 1ns / 1ps

module nca_checker
  import nca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  nca_in_if                elem,
  nca_out_if               result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);

  localparam int MAX_SHOWN = 10;
  localparam logic [ACC_W-1:0] SUM_CEIL = '1;

  typedef struct packed {
    logic [CIDX_W-1:0] cluster;
    logic [ACC_W-1:0]  distance;
  } assignment_t;

  logic signed [VAL_W-1:0] center_mem [NUM_CENTERS][NUM_DIMS];
  logic [ACC_W-1:0]        dist_sums [NUM_CENTERS];
  logic [CFG_W-1:0]        ncent_cfg;
  logic [CFG_W-1:0]        ndim_cfg;
  assignment_t             awaited_assignments [$];

  function automatic int in_use(input logic [CFG_W-1:0] v, input int hi);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > hi) n = hi;
    return n;
  endfunction

  task automatic predict_element(input cmd_t op, input logic [CIDX_W-1:0] ci,
                                 input logic [DIDX_W-1:0] ei,
                                 input logic signed [VAL_W-1:0] v);
    int nc;
    int nd;
    int best;
    logic signed [VAL_W:0]     diff;
    logic signed [2*VAL_W+1:0] prod;
    logic [ACC_W-1:0]          base;
    logic [ACC_W:0]            total;
    logic [ACC_W-1:0]          best_d;
    assignment_t               pick;
    nc = in_use(ncent_cfg, NUM_CENTERS);
    nd = in_use(ndim_cfg, NUM_DIMS);
    if (op == CMD_LOAD) begin
      center_mem[ci][ei] = v;
    end else if (int'(ei) < nd) begin
      for (int c = 0; c < nc; c++) begin
        diff  = v - center_mem[c][ei];
        prod  = diff * diff;
        base  = (ei == '0) ? '0 : dist_sums[c];
        total = {1'b0, base} + {{(ACC_W + 1 - SQ_W){1'b0}}, prod[SQ_W-1:0]};
        dist_sums[c] = total[ACC_W] ? SUM_CEIL : total[ACC_W-1:0];
      end
      if (int'(ei) == nd - 1) begin
        best   = 0;
        best_d = dist_sums[0];
        for (int c = 1; c < nc; c++) begin
          if (dist_sums[c] < best_d) begin
            best   = c;
            best_d = dist_sums[c];
          end
        end
        pick.cluster  = CIDX_W'(best);
        pick.distance = best_d;
        awaited_assignments = {awaited_assignments, pick};
      end
    end
  endtask

  task automatic flag(input string what, input logic [ACC_W-1:0] want,
                      input logic [ACC_W-1:0] got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  task automatic check_assignment(input logic [CIDX_W-1:0] idx,
                                  input logic [ACC_W-1:0] distance);
    assignment_t want;
    if (awaited_assignments.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t: unexpected assignment: cluster %0d distance %0d", $time, idx,
                 distance);
    end else begin
      want = awaited_assignments.pop_front();
      if (idx !== want.cluster) flag("cluster_index", ACC_W'(want.cluster), ACC_W'(idx));
      if (distance !== want.distance) flag("min_distance", want.distance, distance);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ncent_cfg = CFG_W'(16);
      ndim_cfg  = CFG_W'(16);
      for (int c = 0; c < NUM_CENTERS; c++) dist_sums[c] = '0;
      awaited_assignments.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CENTERS) ncent_cfg = cfg_data;
        else ndim_cfg = cfg_data;
      end
      if (result.valid && result.ready)
        check_assignment(result.cluster_index, result.min_distance);
      if (elem.valid && elem.ready)
        predict_element(cmd_t'(elem.cmd), elem.center_index, elem.element_index, elem.value);
    end
    pending = awaited_assignments.size();
  end

endmodule

/* tb/sv/tb_nearest_center_assign.sv */
// Testbench top for nearest_center_assign: clock, reset, center loads, point
// streams, register phases and random back-pressure; verdict from nca_checker.
// Depends on nca_pkg, nca_if, nca_checker and the block itself.
`timescale 1ns / 1ps

module tb_nearest_center_assign;
  import nca_pkg::*;

  localparam int ITEMS        = 1450;
  localparam int DRAIN_CYCLES = 120;
  localparam int LIMIT        = 500000;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int               mismatches;
  int               pending;
  int unsigned      cycles = 0;

  bit calm   = 1'b0;
  bit narrow = 1'b0;
  int counted = 0;
  int nc_now  = NUM_CENTERS;
  int nd_now  = NUM_DIMS;
  logic signed [VAL_W-1:0] shadow [NUM_CENTERS][NUM_DIMS];

  nca_in_if  elem_ch ();
  nca_out_if res_ch ();

  nearest_center_assign u_dut (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nca_checker u_chk (
    .clk       (clk),
    .rst       (rst),
    .elem      (elem_ch),
    .result    (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (mismatches),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int effective(input logic [CFG_W-1:0] v, input int hi);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > hi) n = hi;
    return n;
  endfunction

  function automatic logic signed [VAL_W-1:0] any_value(input bit near_zero);
    int t;
    t = $urandom_range(0, 15);
    if (t == 0) return 16'sh7FFF;
    if (t == 1) return 16'sh8000;
    if (near_zero) return VAL_W'(int'($urandom_range(0, 8)) - 4);
    return VAL_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [CFG_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0:       return CFG_W'($urandom_range(0, 1));
      1:       return CFG_W'($urandom_range(16, 31));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send(input cmd_t op, input logic [CIDX_W-1:0] ci,
                      input logic [DIDX_W-1:0] ei, input logic signed [VAL_W-1:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      elem_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    elem_ch.valid         <= 1'b1;
    elem_ch.cmd           <= op;
    elem_ch.center_index  <= ci;
    elem_ch.element_index <= ei;
    elem_ch.value         <= v;
    do @(posedge clk); while (!elem_ch.ready);
    if (op == CMD_LOAD) shadow[ci][ei] = v;
    if (op == CMD_LOAD || int'(ei) < nd_now) counted++;
  endtask

  // wait for every assignment, then let the job queue empty
  task automatic settle();
    elem_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (r == CFG_CENTERS) nc_now = effective(d, NUM_CENTERS);
    else nd_now = effective(d, NUM_DIMS);
  endtask

  initial begin : result_sink
    int hold;
    res_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
    end
  end

  initial begin : stimulus
    int kind;
    int tie_src;
    int a;
    int b;
    int k;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_CENTERS;
    cfg_data              <= '0;
    elem_ch.valid         <= 1'b0;
    elem_ch.cmd           <= CMD_LOAD;
    elem_ch.center_index  <= '0;
    elem_ch.element_index <= '0;
    elem_ch.value         <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole center table so no point reads an unwritten entry
    for (int c = 0; c < NUM_CENTERS; c++)
      for (int e = 0; e < NUM_DIMS; e++)
        send(CMD_LOAD, CIDX_W'(c), DIDX_W'(e), any_value(1'b0));
    settle();

    // two centers at opposite extremes, one dimension
    write_reg(CFG_CENTERS, CFG_W'(2));
    write_reg(CFG_DIMS, CFG_W'(1));
    send(CMD_LOAD, 4'd0, 4'd0, 16'sh7FFF);
    send(CMD_LOAD, 4'd1, 4'd0, 16'sh8000);
    send(CMD_POINT, 4'd15, 4'd0, 16'sh8000);
    send(CMD_POINT, 4'd0, 4'd0, 16'sh7FFF);
    send(CMD_POINT, 4'd9, 4'd0, -16'sd1);
    send(CMD_POINT, 4'd3, 4'd15, 16'sd12345);
    send(CMD_LOAD, 4'd0, 4'd0, 16'sd100);
    send(CMD_LOAD, 4'd1, 4'd0, -16'sd100);
    send(CMD_POINT, 4'd6, 4'd0, 16'sd0);
    settle();

    // sums keep growing without element 0 until they saturate
    write_reg(CFG_CENTERS, CFG_W'(0));
    write_reg(CFG_DIMS, CFG_W'(2));
    send(CMD_LOAD, 4'd0, 4'd0, 16'sh7FFF);
    send(CMD_LOAD, 4'd0, 4'd1, 16'sh7FFF);
    send(CMD_POINT, 4'd0, 4'd0, 16'sh8000);
    repeat (16) send(CMD_POINT, 4'd0, 4'd1, 16'sh8000);
    settle();
    write_reg(CFG_CENTERS, CFG_W'(31));
    write_reg(CFG_DIMS, CFG_W'(31));

    while (counted < ITEMS) begin
      settle();
      write_reg(CFG_CENTERS, pick_reg());
      write_reg(CFG_DIMS, pick_reg());
      calm   = ($urandom_range(0, 3) == 0);
      narrow = ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(3, 10)) begin
        kind = $urandom_range(0, 19);
        if (kind < 13) begin
          tie_src = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nc_now - 1) : -1;
          for (int e = 0; e < nd_now; e++)
            send(CMD_POINT, CIDX_W'($urandom), DIDX_W'(e),
                 (tie_src >= 0) ? shadow[tie_src][e] : any_value(narrow));
        end else if (kind < 15) begin
          repeat ($urandom_range(1, 4))
            send(CMD_LOAD, CIDX_W'($urandom), DIDX_W'($urandom), any_value(narrow));
        end else if (kind == 15) begin
          // duplicate a center so ties resolve to the lower index
          a = $urandom_range(0, NUM_CENTERS - 1);
          b = $urandom_range(0, NUM_CENTERS - 1);
          for (int e = 0; e < nd_now; e++)
            send(CMD_LOAD, CIDX_W'(b), DIDX_W'(e), shadow[a][e]);
        end else if (kind < 18) begin
          repeat ($urandom_range(1, 6))
            send(CMD_POINT, CIDX_W'($urandom), DIDX_W'($urandom), any_value(narrow));
        end else if (nd_now >= 2) begin
          k = $urandom_range(0, nd_now - 2);
          for (int e = 0; e <= k; e++)
            send(CMD_POINT, CIDX_W'($urandom), DIDX_W'(e), any_value(narrow));
        end
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
